[hw/rtl/usbsx_pkg.sv]
// ----------------------------------------------------------------------------
// USB-MIDI SysEx packetizer package
// Shared types and constants for the SysEx event packet framing block.
// ----------------------------------------------------------------------------
package usbsx_pkg;

  // Byte that ends a SysEx message.
  localparam logic [7:0] END_OF_SYSEX = 8'hF7;

  // Code index for a start or continue packet; end codes are this plus the count.
  localparam logic [3:0] CODE_CONTINUE = 4'd4;

  // Group fill level at which the next byte closes the group (third byte).
  localparam logic [1:0] GROUP_LAST = 2'd2;

  // Transfer buffer size in bytes and the resulting packet limit.
  localparam int BUFFER_BYTES = 512;
  localparam int PKT_LIMIT    = BUFFER_BYTES / 4;
  localparam int PKT_W        = $clog2(PKT_LIMIT + 1);

  // Chunk threshold register.
  localparam int               CHUNK_W     = 9;
  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 9'd64;

  // Byte counter holds at most three bytes per packet up to the packet limit.
  localparam int BYTES_W = $clog2(3 * PKT_LIMIT + 1);
  localparam int CNT_W   = (BYTES_W > CHUNK_W) ? BYTES_W : CHUNK_W;

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_CHUNK_BYTES = 1'b0;  // register index, taken from paddr[2]

  // One closed group on its way from the front to the back.
  typedef struct packed {
    logic [3:0] cable;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] count;   // bytes in the group, 1 to 3
    logic       ended;   // closed by the end-of-SysEx byte
    logic       last;    // closed by the last byte of the buffer
  } grp_t;

  // One finished event packet.
  typedef struct packed {
    logic [7:0] header;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic       flush_after;
    logic       pause_after;
  } res_t;

  // Queue status seen by the modules on either side of it.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[hw/rtl/usbsx_front.sv]
// ----------------------------------------------------------------------------
// SysEx group builder
// Gathers accepted bytes into groups of up to three and hands each closed
// group to the group queue in the cycle its closing byte is accepted.
// ----------------------------------------------------------------------------
module usbsx_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [3:0]        cable,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              grp_push,
  output usbsx_pkg::grp_t   grp
);

  logic [1:0] count;
  logic [1:0] count_next;
  logic [7:0] b0;
  logic [7:0] b1;
  logic       ended;
  logic       closing;

  // Classify the incoming byte.
  assign ended   = (data_byte == usbsx_pkg::END_OF_SYSEX);
  assign closing = ended || last_byte || (count == usbsx_pkg::GROUP_LAST);
  assign grp_push = accept && closing;

  // Assemble the closed group; slots past the closing byte read as zero.
  always_comb begin
    grp.cable = cable;
    grp.b0    = (count == 2'd0) ? data_byte : b0;
    grp.b1    = (count == 2'd0) ? 8'd0 : ((count == 2'd1) ? data_byte : b1);
    grp.b2    = (count == usbsx_pkg::GROUP_LAST) ? data_byte : 8'd0;
    grp.count = count + 2'd1;
    grp.ended = ended;
    grp.last  = last_byte;
  end

  // Fill level of the open group.
  always_comb begin
    count_next = count;
    if (accept) begin
      count_next = closing ? 2'd0 : (count + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // Bytes of the open group.
  always_ff @(posedge clk) begin
    if (accept && !closing) begin
      if (count == 2'd0) begin
        b0 <= data_byte;
      end else begin
        b1 <= data_byte;
      end
    end
  end

  // The open group never holds three bytes between beats.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("open group holds three bytes");

  // A group holding two bytes always closes on the next accepted byte.
  a_third_closes: assert property (@(posedge clk) disable iff (rst)
    (accept && count == usbsx_pkg::GROUP_LAST) |-> grp_push)
    else $error("third byte did not close the group");

endmodule

[hw/rtl/usbsx_grpq.sv]
// ----------------------------------------------------------------------------
// Group queue
// Two-entry queue of closed groups between the group builder and the
// packet stage, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module usbsx_grpq (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  usbsx_pkg::grp_t     wr_data,
  input  logic                rd_en,
  output usbsx_pkg::grp_t     rd_data,
  output usbsx_pkg::q_stat_t  stat
);

  usbsx_pkg::grp_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = mem[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/usbsx_back.sv]
// ----------------------------------------------------------------------------
// Packet stage
// Takes closed groups, keeps the per-transfer byte and packet counters,
// forms the event packet with its flush and pause flags, and holds finished
// packets in a two-entry result queue.
// ----------------------------------------------------------------------------
module usbsx_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [usbsx_pkg::CHUNK_W-1:0] chunk_bytes,
  input  usbsx_pkg::q_stat_t            grp_stat,
  input  usbsx_pkg::grp_t               grp,
  output logic                          grp_pop,
  input  logic                          pop,
  output logic                          empty,
  output usbsx_pkg::res_t               res
);

  logic [usbsx_pkg::CNT_W-1:0] bytes_since_flush;
  logic [usbsx_pkg::CNT_W-1:0] bytes_next;
  logic [usbsx_pkg::PKT_W-1:0] packets_in_transfer;
  logic [usbsx_pkg::PKT_W-1:0] packets_next;
  logic                        flush;
  logic [3:0]                  code;
  usbsx_pkg::res_t             pkt;

  usbsx_pkg::res_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_rd;

  // Take a group whenever the result queue has room.
  assign grp_pop = !grp_stat.empty && (count != 2'd2);
  assign do_rd   = pop && !empty;
  assign empty   = (count == 2'd0);
  assign res     = mem[rd_ptr];

  // Counters as they stand with this group counted.
  assign packets_next = packets_in_transfer + usbsx_pkg::PKT_W'(1);
  assign bytes_next   = bytes_since_flush + usbsx_pkg::CNT_W'(grp.count);

  // A transfer closes at the chunk threshold, the packet limit, end of SysEx
  // or the last byte of the buffer.
  assign flush = (bytes_next >= usbsx_pkg::CNT_W'(chunk_bytes)) ||
                 (packets_next >= usbsx_pkg::PKT_W'(usbsx_pkg::PKT_LIMIT)) ||
                 grp.ended || grp.last;

  assign code = grp.ended ? (usbsx_pkg::CODE_CONTINUE + {2'b00, grp.count})
                          : usbsx_pkg::CODE_CONTINUE;

  // Event packet.
  always_comb begin
    pkt.header      = {grp.cable, code};
    pkt.first_byte  = grp.b0;
    pkt.second_byte = grp.b1;
    pkt.third_byte  = grp.b2;
    pkt.flush_after = flush;
    pkt.pause_after = flush && !grp.ended && !grp.last;
  end

  // Transfer counters, cleared at every flush.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_since_flush   <= '0;
      packets_in_transfer <= '0;
    end else if (grp_pop) begin
      if (flush) begin
        bytes_since_flush   <= '0;
        packets_in_transfer <= '0;
      end else begin
        bytes_since_flush   <= bytes_next;
        packets_in_transfer <= packets_next;
      end
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (grp_pop) begin
      mem[wr_ptr] <= pkt;
    end
  end

  // Result queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (grp_pop) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({grp_pop, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // The result queue never overfills.
  a_resq_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result queue overflow");

  // The packet counter never passes the buffer limit.
  a_pkt_limit: assert property (@(posedge clk) disable iff (rst)
    packets_in_transfer < usbsx_pkg::PKT_W'(usbsx_pkg::PKT_LIMIT))
    else $error("packet counter passed the buffer limit");

  // A flushed packet leaves both counters cleared.
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (grp_pop && flush) |=> (bytes_since_flush == '0 && packets_in_transfer == '0))
    else $error("counters not cleared after flush");

endmodule

[hw/rtl/usb_midi_sysex_packetizer.sv]
// ----------------------------------------------------------------------------
// USB-MIDI SysEx packetizer
// Frames a SysEx byte stream into 4-byte USB-MIDI event packets and marks
// where each bulk transfer closes and where the sender must pause.
//
//   Channel  Direction  Handshake              Payload
//   input    in         push / full            cable, data_byte, last_byte
//   result   out        empty / pop            header, first_byte .. third_byte,
//                                              flush_after, pause_after
//   config   in         APB psel/penable/...   chunk_bytes at address 0
//
// One byte is accepted per cycle while full is low; a packet reaches the result
// ports through the group queue and then the result queue, and can be popped
// once empty is low. Reset is synchronous: queues empty, open group and
// transfer counters cleared, chunk_bytes back to 64. A stalled result side
// fills the two-entry result queue and then the two-entry group queue; full
// rises only when the group queue is full.
// ----------------------------------------------------------------------------
module usb_midi_sysex_packetizer (
  input  logic                         clk,
  input  logic                         rst,
  // Input beats
  input  logic                         push,
  output logic                         full,
  input  logic [3:0]                   cable,
  input  logic [7:0]                   data_byte,
  input  logic                         last_byte,
  // Result beats
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   header,
  output logic [7:0]                   first_byte,
  output logic [7:0]                   second_byte,
  output logic [7:0]                   third_byte,
  output logic                         flush_after,
  output logic                         pause_after,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [usbsx_pkg::ADDR_W-1:0] paddr,
  input  logic [usbsx_pkg::DATA_W-1:0] pwdata,
  output logic [usbsx_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);

  logic [usbsx_pkg::CHUNK_W-1:0] chunk_bytes;
  logic                          accept;
  logic                          grp_push;
  logic                          grp_pop;
  usbsx_pkg::grp_t               grp_in;
  usbsx_pkg::grp_t               grp_out;
  usbsx_pkg::q_stat_t            grp_stat;
  usbsx_pkg::res_t               res;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes <= usbsx_pkg::CHUNK_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == usbsx_pkg::REG_CHUNK_BYTES)) begin
      chunk_bytes <= pwdata[usbsx_pkg::CHUNK_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == usbsx_pkg::REG_CHUNK_BYTES) begin
      prdata = usbsx_pkg::DATA_W'(chunk_bytes);
    end
  end

  // Input handshake.
  assign full   = grp_stat.full;
  assign accept = push && !full;

  usbsx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cable     (cable),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .grp_push  (grp_push),
    .grp       (grp_in)
  );

  usbsx_grpq u_grpq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (grp_push),
    .wr_data (grp_in),
    .rd_en   (grp_pop),
    .rd_data (grp_out),
    .stat    (grp_stat)
  );

  usbsx_back u_back (
    .clk         (clk),
    .rst         (rst),
    .chunk_bytes (chunk_bytes),
    .grp_stat    (grp_stat),
    .grp         (grp_out),
    .grp_pop     (grp_pop),
    .pop         (pop),
    .empty       (empty),
    .res         (res)
  );

  // Result fields.
  assign header      = res.header;
  assign first_byte  = res.first_byte;
  assign second_byte = res.second_byte;
  assign third_byte  = res.third_byte;
  assign flush_after = res.flush_after;
  assign pause_after = res.pause_after;

endmodule

[test/usb_midi_sysex_packetizer_tb.sv]
// ----------------------------------------------------------------------------
// USB-MIDI SysEx packetizer testbench
// Sends SysEx byte streams with random gaps on the input side and random
// stalls on the result side. Each packet is checked field by field against a
// local framing predictor or a directed row's packet. A short directed table
// comes first. Then random messages run under several chunk settings, extremes too.
// ----------------------------------------------------------------------------
module usb_midi_sysex_packetizer_tb;

  localparam int          CYCLE_LIMIT    = 300000;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          GROUP_MAX      = 3;
  localparam int          PHASE_BYTES    = 50;
  localparam int          LONG_MESSAGE   = 395;
  localparam int          DIRECTED_ROWS  = 22;
  localparam int          FIXED_SETTINGS = 7;
  localparam int          SETTING_COUNT  = 9;
  localparam logic [7:0]  SYSEX_START    = 8'hF0;
  localparam logic [usbsx_pkg::ADDR_W-1:0] CHUNK_ADDR = {usbsx_pkg::REG_CHUNK_BYTES, 2'b00};
  localparam usbsx_pkg::res_t NO_PACKET  = '0;

  // One row of the directed table; want is used only where typed is set.
  typedef struct packed {
    logic [3:0]      cab;
    logic [7:0]      b;
    logic            lst;
    logic            typed;
    usbsx_pkg::res_t want;
  } plan_row_t;

  localparam plan_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{4'h0, 8'hF0, 1'b0, 1'b0, NO_PACKET},
    '{4'h0, 8'h00, 1'b0, 1'b0, NO_PACKET},
    // End byte as third byte of the group.
    '{4'h0, 8'hF7, 1'b0, 1'b1, '{8'h07, 8'hF0, 8'h00, 8'hF7, 1'b1, 1'b0}},
    // End byte alone.
    '{4'hF, 8'hF7, 1'b0, 1'b1, '{8'hF5, 8'hF7, 8'h00, 8'h00, 1'b1, 1'b0}},
    '{4'h3, 8'h7F, 1'b0, 1'b0, NO_PACKET},
    '{4'h3, 8'hF7, 1'b0, 1'b1, '{8'h36, 8'h7F, 8'hF7, 8'h00, 1'b1, 1'b0}},
    // Last byte closes a one-byte group.
    '{4'h5, 8'hFF, 1'b1, 1'b1, '{8'h54, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b0}},
    // Cable changes inside a group; the closing byte's cable wins.
    '{4'h1, 8'h00, 1'b0, 1'b0, NO_PACKET},
    '{4'h2, 8'h55, 1'b0, 1'b0, NO_PACKET},
    '{4'hA, 8'hAA, 1'b0, 1'b1, '{8'hA4, 8'h00, 8'h55, 8'hAA, 1'b0, 1'b0}},
    '{4'h4, 8'h12, 1'b0, 1'b0, NO_PACKET},
    '{4'h4, 8'h34, 1'b1, 1'b1, '{8'h44, 8'h12, 8'h34, 8'h00, 1'b1, 1'b0}},
    // End byte that is also the last byte.
    '{4'h6, 8'hF7, 1'b1, 1'b1, '{8'h65, 8'hF7, 8'h00, 8'h00, 1'b1, 1'b0}},
    '{4'h7, 8'hF0, 1'b0, 1'b0, NO_PACKET},
    '{4'h7, 8'h01, 1'b0, 1'b0, NO_PACKET},
    '{4'h7, 8'hF7, 1'b0, 1'b1, '{8'h77, 8'hF0, 8'h01, 8'hF7, 1'b1, 1'b0}},
    // Bytes after the end byte without last_byte form an ordinary group.
    '{4'h7, 8'h02, 1'b0, 1'b0, NO_PACKET},
    '{4'h7, 8'h03, 1'b0, 1'b0, NO_PACKET},
    '{4'h7, 8'h04, 1'b0, 1'b1, '{8'h74, 8'h02, 8'h03, 8'h04, 1'b0, 1'b0}},
    '{4'h8, 8'h80, 1'b0, 1'b0, NO_PACKET},
    '{4'h9, 8'h7F, 1'b0, 1'b0, NO_PACKET},
    '{4'hF, 8'hFF, 1'b1, 1'b0, NO_PACKET}
  };

  localparam logic [8:0] CHUNK_PLAN [FIXED_SETTINGS] = '{
    9'd1, 9'd384, 9'd0, 9'd511, 9'd2, 9'd5, 9'd64
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push;
  logic                full;
  logic [3:0]          cable;
  logic [7:0]          data_byte;
  logic                last_byte;
  logic                empty;
  logic                pop;
  logic [7:0]          header;
  logic [7:0]          first_byte;
  logic [7:0]          second_byte;
  logic [7:0]          third_byte;
  logic                flush_after;
  logic                pause_after;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [usbsx_pkg::ADDR_W-1:0] paddr;
  logic [usbsx_pkg::DATA_W-1:0] pwdata;
  logic [usbsx_pkg::DATA_W-1:0] prdata;
  logic                pready;

  // Predictor state: open group, transfer counters and chunk setting.
  logic [7:0]          open_grp [GROUP_MAX];
  int                  open_cnt;
  int                  xfer_bytes;
  int                  xfer_pkts;
  logic [8:0]          chunk_setting;

  usbsx_pkg::res_t     pending_packets [$];
  int                  fail_count;
  int                  bytes_pushed;
  int                  cycle_count;
  bit                  send_steady;

  usb_midi_sysex_packetizer dut (.*);

  always #2 clk = ~clk;

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Adds one byte to the open group; returns 1 with the packet when it closes.
  function automatic bit frame_byte(input logic [3:0] cab, input logic [7:0] b,
                                    input logic lst, output usbsx_pkg::res_t pkt);
    logic       ended;
    logic [3:0] code;
    logic       flush;
    ended = (b == usbsx_pkg::END_OF_SYSEX);
    pkt = NO_PACKET;
    open_grp[open_cnt] = b;
    open_cnt++;
    if (!(ended || open_cnt == GROUP_MAX || lst)) return 1'b0;
    code = ended ? 4'(usbsx_pkg::CODE_CONTINUE + open_cnt) : usbsx_pkg::CODE_CONTINUE;
    xfer_pkts++;
    xfer_bytes += open_cnt;
    flush = (xfer_bytes >= int'(chunk_setting)) ||
            (xfer_pkts * 4 + 4 > usbsx_pkg::BUFFER_BYTES) || ended || lst;
    pkt.header      = {cab, code};
    pkt.first_byte  = open_grp[0];
    pkt.second_byte = (open_cnt > 1) ? open_grp[1] : 8'h00;
    pkt.third_byte  = (open_cnt > 2) ? open_grp[2] : 8'h00;
    pkt.flush_after = flush;
    pkt.pause_after = flush && !ended && !lst;
    open_cnt = 0;
    if (flush) begin
      xfer_bytes = 0;
      xfer_pkts  = 0;
    end
    return 1'b1;
  endfunction

  // One input beat after a random gap; the prediction is taken on acceptance.
  task automatic send_byte(input logic [3:0] cab, input logic [7:0] b, input logic lst,
                           input logic typed, input usbsx_pkg::res_t want);
    int              gap;
    usbsx_pkg::res_t pkt;
    if ($urandom_range(0, 31) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    cable     <= cab;
    data_byte <= b;
    last_byte <= lst;
    do @(posedge clk); while (full);
    bytes_pushed++;
    if (frame_byte(cab, b, lst, pkt)) pending_packets.push_back(typed ? want : pkt);
  endtask

  // Holds the input side until every packet has come out and the pipe is quiet.
  task automatic settle();
    push <= 1'b0;
    while (pending_packets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write of chunk_bytes, or a read checked against the given value.
  task automatic apb_xfer(input bit wr, input logic [8:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CHUNK_ADDR;
    pwdata  <= usbsx_pkg::DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) chunk_setting = val;
    else check_field("chunk_bytes", usbsx_pkg::DATA_W'(val), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // A SysEx message with random content; some are noise or cut short.
  task automatic send_message(input int len);
    logic [3:0] cab;
    logic [7:0] b;
    logic       lst;
    bit         noise;
    bit         cut;
    cab   = 4'($urandom_range(0, 15));
    noise = ($urandom_range(0, 4) == 0);
    cut   = ($urandom_range(0, 7) == 0);
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(0, 15) == 0) cab = 4'($urandom_range(0, 15));
      lst = 1'b0;
      if (noise) begin
        b   = 8'($urandom_range(0, 255));
        lst = ($urandom_range(0, 7) == 0);
      end else if (n == len - 1) begin
        b   = cut ? 8'($urandom_range(0, 127)) : usbsx_pkg::END_OF_SYSEX;
        lst = cut || ($urandom_range(0, 3) == 0);
      end else if (n == 0) begin
        b = SYSEX_START;
      end else begin
        b = 8'($urandom_range(0, 127));
      end
      send_byte(cab, b, lst, 1'b0, NO_PACKET);
    end
  endtask

  // Result side: random stalls, each accepted beat checked against the oldest.
  initial begin : result_side
    usbsx_pkg::res_t want;
    int              gap;
    bit              take_steady;
    take_steady = 1'b0;
    pop <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      if ($urandom_range(0, 31) == 0) take_steady = !take_steady;
      gap = take_steady ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (pending_packets.size() == 0) begin
        $error("packet beat with nothing expected: header %0h", header);
        fail_count++;
      end else begin
        want = pending_packets.pop_front();
        check_field("header", 32'(want.header), 32'(header));
        check_field("first_byte", 32'(want.first_byte), 32'(first_byte));
        check_field("second_byte", 32'(want.second_byte), 32'(second_byte));
        check_field("third_byte", 32'(want.third_byte), 32'(third_byte));
        check_field("flush_after", 32'(want.flush_after), 32'(flush_after));
        check_field("pause_after", 32'(want.pause_after), 32'(pause_after));
      end
    end
  end

  // Input and configuration side.
  initial begin : stream_side
    logic [8:0] setting;
    int         phase_start;
    push      <= 1'b0;
    cable     <= '0;
    data_byte <= '0;
    last_byte <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    for (int i = 0; i < GROUP_MAX; i++) open_grp[i] = 8'h00;
    open_cnt      = 0;
    xfer_bytes    = 0;
    xfer_pkts     = 0;
    chunk_setting = usbsx_pkg::CHUNK_RESET;
    fail_count    = 0;
    bytes_pushed  = 0;
    send_steady   = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset value of the chunk register, then the directed table.
    apb_xfer(1'b0, usbsx_pkg::CHUNK_RESET);
    for (int r = 0; r < DIRECTED_ROWS; r++)
      send_byte(DIRECTED[r].cab, DIRECTED[r].b, DIRECTED[r].lst,
                DIRECTED[r].typed, DIRECTED[r].want);
    settle();

    // Random messages under each chunk setting.
    for (int p = 0; p < SETTING_COUNT; p++) begin
      setting = (p < FIXED_SETTINGS) ? CHUNK_PLAN[p] : 9'($urandom_range(1, 384));
      apb_xfer(1'b1, setting);
      apb_xfer(1'b0, setting);
      phase_start = bytes_pushed;
      // At 511 the packet limit, not the chunk size, closes long transfers.
      if (setting == 9'd511) send_message(LONG_MESSAGE);
      while (bytes_pushed - phase_start < PHASE_BYTES) begin
        send_message(($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
                                                 : $urandom_range(1, 24));
        if ($urandom_range(0, 15) == 0) settle();
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/usbsx_pkg.sv
hw/rtl/usbsx_front.sv
hw/rtl/usbsx_grpq.sv
hw/rtl/usbsx_back.sv
hw/rtl/usb_midi_sysex_packetizer.sv
test/usb_midi_sysex_packetizer_tb.sv
